/* design/afma_pkg.sv */
`timescale 1ns / 1ps

package afma_pkg;

  localparam int COORD_W    = 24;
  localparam int MAG_W      = 24;
  localparam int SQ_W       = 48;
  localparam int SSUM_W     = 50;
  localparam int DIST_W     = 25;
  localparam int REM_W      = 26;
  localparam int STIFF_W    = 10;
  localparam int DZ_W       = 24;
  localparam int FORCE_W    = 16;
  localparam int WLEN_W     = 7;
  localparam int PROD_W     = 35;
  localparam int LIMIT_W    = 27;
  localparam int QUO_W      = 16;
  localparam int FDIV_W     = 10;
  localparam int FORCE_DIV  = 1000;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MUL_CNT_W  = 4;
  localparam int SQR_CNT_W  = 5;
  localparam int ROOT_CNT_W = 5;
  localparam int DIV_CNT_W  = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [FORCE_W-1:0]        force_t;
  typedef logic [CFG_ADDR_W-1:0]     cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam cfg_addr_t REG_STIFFNESS = 2'd0;
  localparam cfg_addr_t REG_DEADZONE  = 2'd1;
  localparam cfg_addr_t REG_MAX_FORCE = 2'd2;
  localparam cfg_addr_t REG_WINDOW    = 2'd3;

  localparam logic [STIFF_W-1:0] STIFFNESS_RST = 10'd10;
  localparam logic [DZ_W-1:0]    DEADZONE_RST  = 24'd30000;
  localparam logic [FORCE_W-1:0] MAX_FORCE_RST = 16'd7000;
  localparam logic [WLEN_W-1:0]  WINDOW_RST    = 7'd50;

endpackage

/* design/afma_if.sv */
`timescale 1ns / 1ps

interface afma_in_if import afma_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t effector_x;
  coord_t effector_y;
  coord_t effector_z;
  coord_t goal_x;
  coord_t goal_y;
  coord_t goal_z;

  modport source (
    output valid, effector_x, effector_y, effector_z, goal_x, goal_y, goal_z,
    input  ready
  );
  modport sink (
    input  valid, effector_x, effector_y, effector_z, goal_x, goal_y, goal_z,
    output ready
  );
endinterface

interface afma_out_if import afma_pkg::*; ();
  logic   valid;
  logic   ready;
  force_t force_average;
  force_t force_raw;

  modport source (output valid, force_average, force_raw, input ready);
  modport sink (input valid, force_average, force_raw, output ready);
endinterface

interface afma_cfg_if import afma_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_addr_t addr;
  cfg_data_t data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* design/afma_ram.sv */
`timescale 1ns / 1ps

module afma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/afma_sqr.sv */
`timescale 1ns / 1ps

module afma_sqr import afma_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  coord_t          a,
  input  coord_t          b,
  output logic            done,
  output logic [SQ_W-1:0] square
);

  logic                 busy_r;
  logic                 done_r;
  logic [SQR_CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0]     mag_r;
  logic [SQ_W-1:0]      prod_r;

  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        diff_neg;
  logic [MAG_W-1:0]        mag;
  logic [MAG_W:0]          step_sum;

  // magnitude of the difference, then shift-add one multiplier bit a cycle
  assign diff     = {b[COORD_W-1], b} - {a[COORD_W-1], a};
  assign diff_neg = -diff;
  assign mag      = diff[COORD_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
  assign step_sum = {1'b0, prod_r[SQ_W-1:MAG_W]} + (prod_r[0] ? {1'b0, mag_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + SQR_CNT_W'(1);
        if (cnt_r == SQR_CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r  <= mag;
      prod_r <= {{MAG_W{1'b0}}, mag};
    end else if (busy_r) begin
      prod_r <= {step_sum, prod_r[MAG_W-1:1]};
    end
  end

  assign done   = done_r;
  assign square = prod_r;

endmodule

/* design/afma_isqrt.sv */
`timescale 1ns / 1ps

module afma_isqrt import afma_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SSUM_W-1:0] radicand,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  logic                  busy_r;
  logic                  done_r;
  logic [ROOT_CNT_W-1:0] cnt_r;
  logic [SSUM_W-1:0]     rad_r;
  logic [REM_W-1:0]      rem_r;
  logic [DIST_W-1:0]     root_r;

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             ge;

  // one root bit per cycle, two radicand bits shifted in
  assign rem2  = {rem_r, rad_r[SSUM_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_r, 2'b01});
  assign ge    = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + ROOT_CNT_W'(1);
        if (cnt_r == ROOT_CNT_W'(DIST_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
      root_r <= {root_r[DIST_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* design/afma_div16.sv */
`timescale 1ns / 1ps

module afma_div16 import afma_pkg::*; #(
  parameter int DVS_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVS_W-1:0] hi,
  input  logic [QUO_W-1:0] lo,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [QUO_W-1:0]     lo_r;

  logic [DVS_W:0] rem2;
  logic [DVS_W:0] dvs_ext;
  logic           ge;

  // restoring division, hi < divisor so the quotient fits in QUO_W bits
  assign rem2    = {rem_r, lo_r[QUO_W-1]};
  assign dvs_ext = {1'b0, dvs_r};
  assign ge      = rem2 >= dvs_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi;
      dvs_r <= divisor;
      lo_r  <= lo;
    end else if (busy_r) begin
      rem_r <= ge ? DVS_W'(rem2 - dvs_ext) : DVS_W'(rem2);
      lo_r  <= {lo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = lo_r;

endmodule

/* design/assist_force_moving_average.sv */
// Assist force with spring law, deadzone, clamp and moving average.
// in_ch takes one word: effector and goal position, x/y/z in micrometres.
// out_ch gives one word per input: averaged force and this sample's raw force.
// cfg_ch writes stiffness, deadzone_distance, max_force and window_length by
// index 0 to 3; it is always ready. The user is to write it only while the
// block is idle; the block does not enforce this. A window_length write
// clears the sample ring, its write slot and the sum. The work is bit serial:
// the three squares in parallel lanes, the square root, the stiffness
// multiply, and the force and the average division on one shared divider,
// plus sequencing. The block takes no new word while it is busy with one;
// in_ch.ready is high while the sequencer is idle, even while a result
// still waits in the output register. A stalled receiver holds the result;
// a finished next result then waits in the sequencer until the output
// register is free.
// Reset: registers take their default values and the ring reads as zero at
// once (no clearing pass; entries count as written only after the first wrap).
`timescale 1ns / 1ps

module assist_force_moving_average import afma_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  afma_in_if.sink     in_ch,
  afma_out_if.source  out_ch,
  afma_cfg_if.sink    cfg_ch
);

  localparam int RING_AW = $clog2(MAX_WINDOW);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W   = FORCE_W + RING_AW;
  localparam int EXT_W   = (WIN_W > WLEN_W) ? WIN_W : WLEN_W;
  localparam int DVS_W   = (WIN_W > FDIV_W) ? WIN_W : FDIV_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQR    = 4'd1;
  localparam logic [3:0] ST_SUM    = 4'd2;
  localparam logic [3:0] ST_ROOT   = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_FCHK   = 4'd5;
  localparam logic [3:0] ST_FDIV   = 4'd6;
  localparam logic [3:0] ST_RING   = 4'd7;
  localparam logic [3:0] ST_ASTART = 4'd8;
  localparam logic [3:0] ST_ADIV   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0]         state_r,   state_nxt;
  logic [STIFF_W-1:0] stiff_r,   stiff_nxt;
  logic [DZ_W-1:0]    dz_r,      dz_nxt;
  logic [FORCE_W-1:0] maxf_r,    maxf_nxt;
  logic [WLEN_W-1:0]  wlen_r,    wlen_nxt;
  logic [RING_AW-1:0] slot_r,    slot_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [SUM_W-1:0]   sum_r,     sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MUL_CNT_W-1:0] mul_cnt_r, mul_cnt_nxt;

  logic [SSUM_W-1:0]  ssum_r,    ssum_nxt;
  logic [PROD_W-1:0]  prod_r,    prod_nxt;
  logic [LIMIT_W-1:0] limit_r,   limit_nxt;
  logic               zero_r,    zero_nxt;
  logic               sat_r,     sat_nxt;
  force_t             force_r,   force_nxt;
  force_t             avg_r,     avg_nxt;
  force_t             out_avg_r, out_avg_nxt;
  force_t             out_raw_r, out_raw_nxt;

  logic               in_acc;
  logic               cfg_acc;
  logic [EXT_W-1:0]   wlen_ext;
  logic [WIN_W-1:0]   eff_win;
  logic [WIN_W-1:0]   slot_inc;

  logic [2:0]         sq_done;
  logic [SQ_W-1:0]    sq_x;
  logic [SQ_W-1:0]    sq_y;
  logic [SQ_W-1:0]    sq_z;

  logic               root_start;
  logic [SSUM_W-1:0]  radicand;
  logic               root_done;
  logic [DIST_W-1:0]  dist_um;

  logic [DIST_W:0]    mul_add;
  logic               below_dz;
  logic               over_limit;

  logic               div_start;
  logic [DVS_W-1:0]   div_hi;
  logic [QUO_W-1:0]   div_lo;
  logic [DVS_W-1:0]   div_dvs;
  logic               div_done;
  logic [QUO_W-1:0]   div_q;

  logic               ram_we;
  force_t             ram_rdata;
  force_t             old_val;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign cfg_ch.ready         = 1'b1;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.force_average = out_avg_r;
  assign out_ch.force_raw     = out_raw_r;

  // window of zero acts as one, above the ring size as the ring size
  assign wlen_ext = EXT_W'(wlen_r);
  always_comb begin
    priority if (wlen_r == '0) begin
      eff_win = WIN_W'(1);
    end else if (wlen_ext > EXT_W'(MAX_WINDOW)) begin
      eff_win = WIN_W'(MAX_WINDOW);
    end else begin
      eff_win = WIN_W'(wlen_r);
    end
  end

  afma_sqr u_sqr_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .a      (in_ch.effector_x),
    .b      (in_ch.goal_x),
    .done   (sq_done[0]),
    .square (sq_x)
  );

  afma_sqr u_sqr_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .a      (in_ch.effector_y),
    .b      (in_ch.goal_y),
    .done   (sq_done[1]),
    .square (sq_y)
  );

  afma_sqr u_sqr_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .a      (in_ch.effector_z),
    .b      (in_ch.goal_z),
    .done   (sq_done[2]),
    .square (sq_z)
  );

  afma_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (dist_um)
  );

  afma_div16 #(.DVS_W(DVS_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .hi      (div_hi),
    .lo      (div_lo),
    .divisor (div_dvs),
    .done    (div_done),
    .quot    (div_q)
  );

  afma_ram #(.WIDTH(FORCE_W), .DEPTH(MAX_WINDOW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (force_r),
    .re    (in_acc),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign radicand   = ssum_r + SSUM_W'(sq_z);
  assign mul_add    = {1'b0, prod_r[PROD_W-1:STIFF_W]} + (prod_r[0] ? {1'b0, dist_um} : '0);
  assign below_dz   = dist_um < DIST_W'(dz_r);
  assign over_limit = prod_r >= PROD_W'(limit_r);
  assign old_val    = wrapped_r ? ram_rdata : '0;
  assign slot_inc   = WIN_W'(slot_r) + WIN_W'(1);

  always_comb begin
    state_nxt     = state_r;
    stiff_nxt     = stiff_r;
    dz_nxt        = dz_r;
    maxf_nxt      = maxf_r;
    wlen_nxt      = wlen_r;
    slot_nxt      = slot_r;
    wrapped_nxt   = wrapped_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    mul_cnt_nxt   = mul_cnt_r;
    ssum_nxt      = ssum_r;
    prod_nxt      = prod_r;
    limit_nxt     = limit_r;
    zero_nxt      = zero_r;
    sat_nxt       = sat_r;
    force_nxt     = force_r;
    avg_nxt       = avg_r;
    out_avg_nxt   = out_avg_r;
    out_raw_nxt   = out_raw_r;
    root_start    = 1'b0;
    div_start     = 1'b0;
    div_hi        = '0;
    div_lo        = '0;
    div_dvs       = DVS_W'(FORCE_DIV);
    ram_we        = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_acc) begin
      unique case (cfg_ch.addr)
        REG_STIFFNESS: stiff_nxt = cfg_ch.data[STIFF_W-1:0];
        REG_DEADZONE:  dz_nxt    = cfg_ch.data[DZ_W-1:0];
        REG_MAX_FORCE: maxf_nxt  = cfg_ch.data[FORCE_W-1:0];
        REG_WINDOW: begin
          wlen_nxt    = cfg_ch.data[WLEN_W-1:0];
          slot_nxt    = '0;
          wrapped_nxt = 1'b0;
          sum_nxt     = '0;
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          // saturation threshold on the product: (max_force + 1) * 1000
          limit_nxt = (LIMIT_W'(maxf_r) + LIMIT_W'(1)) * LIMIT_W'(FORCE_DIV);
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        if (&sq_done) begin
          ssum_nxt  = SSUM_W'(sq_x) + SSUM_W'(sq_y);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          prod_nxt    = {{DIST_W{1'b0}}, stiff_r};
          mul_cnt_nxt = '0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt    = {mul_add, prod_r[STIFF_W-1:1]};
        mul_cnt_nxt = mul_cnt_r + MUL_CNT_W'(1);
        if (mul_cnt_r == MUL_CNT_W'(STIFF_W - 1)) begin
          state_nxt = ST_FCHK;
        end
      end
      ST_FCHK: begin
        zero_nxt  = below_dz;
        sat_nxt   = over_limit;
        div_start = 1'b1;
        if (!below_dz && !over_limit) begin
          div_hi = DVS_W'(prod_r[FORCE_W+FDIV_W-1:FORCE_W]);
          div_lo = prod_r[FORCE_W-1:0];
        end
        state_nxt = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_done) begin
          priority if (zero_r) begin
            force_nxt = '0;
          end else if (sat_r) begin
            force_nxt = maxf_r;
          end else begin
            force_nxt = div_q;
          end
          state_nxt = ST_RING;
        end
      end
      ST_RING: begin
        ram_we  = 1'b1;
        sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(force_r);
        if (slot_inc >= eff_win) begin
          slot_nxt    = '0;
          wrapped_nxt = 1'b1;
        end else begin
          slot_nxt = slot_inc[RING_AW-1:0];
        end
        state_nxt = ST_ASTART;
      end
      ST_ASTART: begin
        div_start = 1'b1;
        div_hi    = DVS_W'(sum_r[SUM_W-1:FORCE_W]);
        div_lo    = sum_r[FORCE_W-1:0];
        div_dvs   = DVS_W'(eff_win);
        state_nxt = ST_ADIV;
      end
      ST_ADIV: begin
        if (div_done) begin
          avg_nxt   = div_q;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_avg_nxt   = avg_r;
          out_raw_nxt   = force_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stiff_r     <= STIFFNESS_RST;
      dz_r        <= DEADZONE_RST;
      maxf_r      <= MAX_FORCE_RST;
      wlen_r      <= WINDOW_RST;
      slot_r      <= '0;
      wrapped_r   <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      mul_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      stiff_r     <= stiff_nxt;
      dz_r        <= dz_nxt;
      maxf_r      <= maxf_nxt;
      wlen_r      <= wlen_nxt;
      slot_r      <= slot_nxt;
      wrapped_r   <= wrapped_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      mul_cnt_r   <= mul_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ssum_r    <= ssum_nxt;
    prod_r    <= prod_nxt;
    limit_r   <= limit_nxt;
    zero_r    <= zero_nxt;
    sat_r     <= sat_nxt;
    force_r   <= force_nxt;
    avg_r     <= avg_nxt;
    out_avg_r <= out_avg_nxt;
    out_raw_r <= out_raw_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(slot_r) < eff_win)
    else $error("ring slot outside window");

  assert property (@(posedge clk) disable iff (!rst_n)
    WIN_W'(sum_r[SUM_W-1:FORCE_W]) < eff_win)
    else $error("running sum exceeds window capacity");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_FDIV || state_r == ST_ADIV))
    else $error("divider finished outside a divide state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RING) |-> (force_r <= maxf_r))
    else $error("raw force above max force");

endmodule

/* tb/assist_force_moving_average_test.sv */
`timescale 1ns / 1ps

module assist_force_moving_average_test;
  import afma_pkg::*;

  localparam int RING_MAX        = 64;
  localparam int WATCHDOG_CYCLES = 2000000;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 250;
  localparam int IDLE_PCT        = 26;
  localparam int HOLD_CYCLES     = 600;
  localparam int TAIL_CYCLES     = 150;
  localparam int PLAN_ROWS       = 37;
  localparam coord_t CMIN        = 24'sh800000;
  localparam coord_t CMAX        = 24'sh7fffff;

  typedef enum logic {STEP_WORD, STEP_REG} step_kind_e;

  typedef struct packed {
    coord_t ex;
    coord_t ey;
    coord_t ez;
    coord_t gx;
    coord_t gy;
    coord_t gz;
  } pose_pair_t;

  typedef struct packed {
    force_t avg;
    force_t raw;
  } force_pair_t;

  typedef struct {
    step_kind_e kind;
    cfg_addr_t  addr;
    cfg_data_t  data;
    coord_t     ex, ey, ez, gx, gy, gz;
    bit         typed;
    force_t     avg;
    force_t     raw;
  } plan_row_t;

  // directed walk: typed rows carry their own expected forces
  plan_row_t plan [PLAN_ROWS] = '{
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 30000, 0, 0, 1, 6, 300},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 29999, 0, 0, 1, 6, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 146, 7000},
    '{STEP_WORD, REG_STIFFNESS, 0, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1, 286, 7000},
    '{STEP_WORD, REG_STIFFNESS, 0, 1234567, -123456, 42, -765432, 654321, -99, 0, 0, 0},
    '{STEP_REG, REG_WINDOW, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 100000, 0, 0, 1, 1000, 1000},
    '{STEP_REG, REG_MAX_FORCE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0, 0},
    '{STEP_REG, REG_MAX_FORCE, 65535, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_REG, REG_STIFFNESS, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 65535, 65535},
    '{STEP_REG, REG_DEADZONE, 16777215, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, 0, 0, CMAX, 0, 0, 1, 65535, 65535},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, 0, 0, 8388606, 0, 0, 1, 0, 0},
    '{STEP_REG, REG_DEADZONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_REG, REG_STIFFNESS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 0, 0},
    '{STEP_REG, REG_STIFFNESS, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 999, 0, 0, 1, 0, 0},
    '{STEP_REG, REG_WINDOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 5000, 0, 0, 1, 5, 5},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, -3000, 0, 0, 1, 3, 3},
    '{STEP_REG, REG_WINDOW, 127, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_REG, REG_STIFFNESS, 1000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 64000, 0, 0, 1, 1000, 64000},
    '{STEP_WORD, REG_STIFFNESS, 0, 64000, 0, 0, 0, 0, 0, 1, 2000, 64000},
    '{STEP_REG, REG_WINDOW, 64, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 1, 2, 2, 0, 0, 0, 1, 0, 3},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 1, 1, 0, 1, 0, 1},
    '{STEP_WORD, REG_STIFFNESS, 0, 5, -8, 77, -7, 300001, -12345, 0, 0, 0},
    '{STEP_REG, REG_WINDOW, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 10000, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 20000, 0, 0, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 0, 0, 30000, 0, 0, 0},
    '{STEP_WORD, REG_STIFFNESS, 0, 0, 0, 0, 0, -40000, 0, 0, 0, 0}
  };

  logic clk;
  logic rst_n;

  afma_in_if  in_ch ();
  afma_out_if out_ch ();
  afma_cfg_if cfg_ch ();

  assist_force_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted block state
  logic [STIFF_W-1:0] stiff_reg = STIFFNESS_RST;
  logic [DZ_W-1:0]    dz_reg    = DEADZONE_RST;
  logic [FORCE_W-1:0] max_reg   = MAX_FORCE_RST;
  logic [WLEN_W-1:0]  win_reg   = WINDOW_RST;
  force_t             ring_mn [RING_MAX] = '{default: '0};
  int                 ring_slot = 0;
  int                 ring_sum  = 0;

  force_pair_t pending_forces [$];
  bit          word_typed;
  force_pair_t typed_forces;
  int          words_sent, results_seen, reg_writes, mismatches;
  int          hold_left, hold_runs, dead_hits, sat_hits;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic bit [63:0] floor_root(bit [63:0] v);
    bit [63:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void apply_reg(cfg_addr_t a, cfg_data_t d);
    case (a)
      REG_STIFFNESS: stiff_reg = d[STIFF_W-1:0];
      REG_DEADZONE:  dz_reg = d[DZ_W-1:0];
      REG_MAX_FORCE: max_reg = d[FORCE_W-1:0];
      REG_WINDOW: begin
        win_reg = d[WLEN_W-1:0];
        ring_mn = '{default: '0};
        ring_slot = 0;
        ring_sum = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic force_pair_t predict_forces(pose_pair_t p);
    longint      dx, dy, dzz;
    bit [63:0]   span_um, f;
    int          win;
    force_pair_t r;
    dx = longint'(p.gx) - longint'(p.ex);
    dy = longint'(p.gy) - longint'(p.ey);
    dzz = longint'(p.gz) - longint'(p.ez);
    span_um = floor_root(64'(dx * dx + dy * dy + dzz * dzz));
    f = '0;
    if (span_um < 64'(dz_reg)) begin
      dead_hits++;
    end else begin
      f = span_um * 64'(stiff_reg) / 64'(FORCE_DIV);
      if (f > 64'(max_reg)) begin
        f = 64'(max_reg);
        sat_hits++;
      end
    end
    win = (win_reg == 0) ? 1 : (int'(win_reg) > RING_MAX) ? RING_MAX : int'(win_reg);
    if (ring_slot >= win) ring_slot = 0;
    ring_sum = ring_sum - int'(ring_mn[ring_slot]) + int'(f[FORCE_W-1:0]);
    ring_mn[ring_slot] = f[FORCE_W-1:0];
    ring_slot = (ring_slot + 1 >= win) ? 0 : ring_slot + 1;
    r.avg = force_t'(ring_sum / win);
    r.raw = f[FORCE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    force_pair_t want;
    pose_pair_t  p;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.addr, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        p = '{in_ch.effector_x, in_ch.effector_y, in_ch.effector_z,
              in_ch.goal_x, in_ch.goal_y, in_ch.goal_z};
        want = predict_forces(p);
        pending_forces.push_back(word_typed ? typed_forces : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_forces.size() == 0) begin
          $error("result word with nothing expected: avg %0d raw %0d",
                 out_ch.force_average, out_ch.force_raw);
          mismatches++;
        end else begin
          want = pending_forces.pop_front();
          if (out_ch.force_average !== want.avg) begin
            $error("force_average: expected %0d, actual %0d", want.avg, out_ch.force_average);
            mismatches++;
          end
          if (out_ch.force_raw !== want.raw) begin
            $error("force_raw: expected %0d, actual %0d", want.raw, out_ch.force_raw);
            mismatches++;
          end
        end
        results_seen++;
      end
    end
  end

  // receiver with two long hold-offs and a calm stretch
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (rst_n && hold_runs < 2 && results_seen >= 400 + hold_runs * 1100) begin
        out_ch.ready = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_runs++;
      end else if (results_seen >= 900 && results_seen < 1200) begin
        out_ch.ready = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic bit sender_calm();
    return words_sent >= 900 && words_sent < 1200;
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v < longint'(CMIN)) return CMIN;
    if (v > longint'(CMAX)) return CMAX;
    return coord_t'(v);
  endfunction

  function automatic coord_t near_coord(coord_t c);
    longint d;
    d = longint'($urandom_range(0, 1 << $urandom_range(0, 22)));
    if ($urandom_range(0, 1)) d = -d;
    return clamp_coord(longint'(c) + d);
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 3))
      0: return CMIN;
      1: return CMAX;
      2: return '0;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic pose_pair_t gen_pose();
    pose_pair_t p;
    int         mode;
    longint     span;
    p = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
          coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
    mode = $urandom_range(0, 9);
    if (mode >= 6 && mode <= 7 && dz_reg >= 24'd16777000) mode = 2;
    case (mode)
      0, 1: ;
      2, 3, 4, 5: begin
        p.gx = near_coord(p.ex);
        p.gy = near_coord(p.ey);
        p.gz = near_coord(p.ez);
      end
      6, 7: begin
        // goal one step around the deadzone edge along x
        span = 64'd16777215 - longint'(dz_reg) - 1;
        p.ex = clamp_coord(longint'(CMIN) + longint'($urandom_range(0, 32'(span))));
        p.gx = clamp_coord(longint'(p.ex) + longint'(dz_reg) + $urandom_range(0, 2) - 1);
        p.gy = p.ey;
        p.gz = p.ez;
      end
      8: p = '{corner_coord(), corner_coord(), corner_coord(),
               corner_coord(), corner_coord(), corner_coord()};
      default: begin
        p.gx = p.ex;
        p.gy = p.ey;
        p.gz = p.ez;
      end
    endcase
    return p;
  endfunction

  task automatic send_word(pose_pair_t p, bit typed, force_pair_t want);
    @(negedge clk);
    while (!sender_calm() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.effector_x = p.ex;
    in_ch.effector_y = p.ey;
    in_ch.effector_z = p.ez;
    in_ch.goal_x = p.gx;
    in_ch.goal_y = p.gy;
    in_ch.goal_z = p.gz;
    word_typed = typed;
    typed_forces = want;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(cfg_addr_t a, cfg_data_t d);
    @(negedge clk);
    cfg_ch.addr = a;
    cfg_ch.data = d;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    reg_writes++;
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (results_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic pick_settings();
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_STIFFNESS, cfg_data_t'(1023));
        1: write_reg(REG_STIFFNESS, cfg_data_t'($urandom_range(0, 20)));
        default: write_reg(REG_STIFFNESS, cfg_data_t'($urandom_range(0, 1023)));
      endcase
    end
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 4))
        0: write_reg(REG_DEADZONE, cfg_data_t'(0));
        1, 2: write_reg(REG_DEADZONE, cfg_data_t'($urandom_range(0, 200000)));
        3: write_reg(REG_DEADZONE, cfg_data_t'($urandom));
        default: write_reg(REG_DEADZONE, cfg_data_t'($urandom_range(0, 2000000)));
      endcase
    end
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 5))
        0: write_reg(REG_MAX_FORCE, cfg_data_t'(65535));
        1: write_reg(REG_MAX_FORCE, cfg_data_t'($urandom_range(0, 100)));
        default: write_reg(REG_MAX_FORCE, cfg_data_t'($urandom_range(0, 65535)));
      endcase
    end
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 7))
        0: write_reg(REG_WINDOW, cfg_data_t'(0));
        1: write_reg(REG_WINDOW, cfg_data_t'(1));
        2: write_reg(REG_WINDOW, cfg_data_t'(2));
        3, 4: write_reg(REG_WINDOW, cfg_data_t'($urandom_range(3, 16)));
        5: write_reg(REG_WINDOW, cfg_data_t'($urandom_range(17, 63)));
        6: write_reg(REG_WINDOW, cfg_data_t'(RING_MAX));
        default: write_reg(REG_WINDOW, cfg_data_t'($urandom_range(65, 127)));
      endcase
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.effector_x = '0;
    in_ch.effector_y = '0;
    in_ch.effector_z = '0;
    in_ch.goal_x = '0;
    in_ch.goal_y = '0;
    in_ch.goal_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = REG_STIFFNESS;
    cfg_ch.data = '0;
    word_typed = 1'b0;
    typed_forces = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_REG) begin
        drain_block();
        write_reg(plan[i].addr, plan[i].data);
      end else begin
        send_word('{plan[i].ex, plan[i].ey, plan[i].ez, plan[i].gx, plan[i].gy, plan[i].gz},
                  plan[i].typed, '{plan[i].avg, plan[i].raw});
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_block();
      pick_settings();
      for (int n = 0; n < WORDS_PER_PHASE; n++) send_word(gen_pose(), 1'b0, '0);
    end

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_forces.size() != 0) begin
      $error("%0d expected results never arrived", pending_forces.size());
      mismatches++;
    end
    $display("covered %0d words, %0d results, %0d register writes, %0d receiver hold-offs",
             words_sent, results_seen, reg_writes, hold_runs);
    $display("forces: %0d inside deadzone, %0d clipped at max_force", dead_hits, sat_hits);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
